// ===== rtl/m4di_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4di_pkg
// Shared types and constants for the 4x4 determinant / inverse block.
// ----------------------------------------------------------------------------
package m4di_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DET_RD,
        ST_DET_MUL,
        ST_DET_ACC,
        ST_ZERO_CHK,
        ST_DIV,
        ST_COF_RD,
        ST_COF_MUL,
        ST_COF_ACC,
        ST_INV_MUL,
        ST_EMIT
    } state_t;

    // Determinant terms: four positions and a subtract flag
    typedef logic [16:0] det_term_t;

    function automatic det_term_t det_term(input logic [4:0] k);
        det_term_t t;
        t = '0;
        case (k)
            5'd0:  t = {4'd0, 4'd5, 4'd10, 4'd15, 1'b0};
            5'd1:  t = {4'd0, 4'd5, 4'd11, 4'd14, 1'b1};
            5'd2:  t = {4'd0, 4'd6, 4'd11, 4'd13, 1'b0};
            5'd3:  t = {4'd0, 4'd6, 4'd9,  4'd15, 1'b1};
            5'd4:  t = {4'd0, 4'd7, 4'd9,  4'd14, 1'b0};
            5'd5:  t = {4'd0, 4'd7, 4'd10, 4'd13, 1'b1};
            5'd6:  t = {4'd1, 4'd6, 4'd11, 4'd12, 1'b1};
            5'd7:  t = {4'd1, 4'd6, 4'd8,  4'd15, 1'b0};
            5'd8:  t = {4'd1, 4'd7, 4'd8,  4'd14, 1'b1};
            5'd9:  t = {4'd1, 4'd7, 4'd10, 4'd12, 1'b0};
            5'd10: t = {4'd1, 4'd4, 4'd10, 4'd15, 1'b1};
            5'd11: t = {4'd1, 4'd4, 4'd11, 4'd14, 1'b0};
            5'd12: t = {4'd2, 4'd7, 4'd8,  4'd13, 1'b0};
            5'd13: t = {4'd2, 4'd7, 4'd9,  4'd12, 1'b1};
            5'd14: t = {4'd2, 4'd4, 4'd9,  4'd15, 1'b0};
            5'd15: t = {4'd2, 4'd4, 4'd11, 4'd13, 1'b1};
            5'd16: t = {4'd2, 4'd5, 4'd11, 4'd12, 1'b0};
            5'd17: t = {4'd2, 4'd5, 4'd8,  4'd15, 1'b1};
            5'd18: t = {4'd3, 4'd4, 4'd9,  4'd14, 1'b1};
            5'd19: t = {4'd3, 4'd4, 4'd10, 4'd13, 1'b0};
            5'd20: t = {4'd3, 4'd5, 4'd10, 4'd12, 1'b1};
            5'd21: t = {4'd3, 4'd5, 4'd8,  4'd14, 1'b0};
            5'd22: t = {4'd3, 4'd6, 4'd8,  4'd13, 1'b1};
            5'd23: t = {4'd3, 4'd6, 4'd9,  4'd12, 1'b0};
            default: t = '0;
        endcase
        return t;
    endfunction

    // Saturating 64-bit add
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    // Saturating 64-bit subtract
    function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

endpackage

// ===== rtl/m4di_fmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4di_fmul
// Multicycle fixed-point multiplier: 64x64 magnitude product built from
// 32x32 partial products, one per cycle, then truncating shift and
// saturation to signed 64 bits.
// ----------------------------------------------------------------------------
module m4di_fmul #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               done,
    output logic signed [63:0] prod
);
    import m4di_pkg::*;

    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [2:0]   step_reg;
    logic         busy_reg;
    logic         done_reg;
    logic signed [63:0] prod_reg;

    logic [31:0]  opa, opb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] q;
    logic [127:0] acc_fin;

    // Select the partial product for this step
    always_comb
    begin
        opa   = step_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        opb   = step_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp    = opa * opb;
        pp_sh = {64'd0, pp} << (32 * (step_reg[1] + step_reg[0]));
        acc_fin = acc_reg + pp_sh;
        q     = acc_fin >> FRAC_BITS;
    end

    // Step through four partial products, then form the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= mag64(a);
            mb_reg  <= mag64(b);
            neg_reg <= a[63] ^ b[63];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_fin;
            if (step_reg == 3'd3)
            begin
                if (neg_reg)
                begin
                    if (q[127:64] != 0 || q[63])
                        prod_reg <= {1'b1, 63'd0};
                    else
                        prod_reg <= 64'd0 - q[63:0];
                end
                else
                begin
                    if (q[127:64] != 0 || q[63])
                        prod_reg <= {1'b0, {63{1'b1}}};
                    else
                        prod_reg <= q[63:0];
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ===== rtl/matrix4_determinant_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_determinant_inverse
// 4x4 fixed-point determinant and adjugate inverse.
// ----------------------------------------------------------------------------
// Usage:
//   Load elements with start/elem_value/elem_index while busy is low; each
//   beat is one element. Every position, 0..15, is stored.
//   A beat at position 15 starts the computation and raises busy.
//   The determinant is summed over 24 terms; each term takes four reads and
//   three chained products on one shared multiplier. A bit-serial divider
//   then forms 2^(2*FRAC_BITS)/|det|. Each of the 16 cofactors takes nine
//   reads, nine products and one scaling product. A singular matrix gives
//   its single beat, with singular set, after the determinant. Results
//   leave one per cycle on the strobe; run_last marks the last one. The
//   receiver cannot stall. Reset clears control and the determinant; the
//   element store is undefined until written.
// ----------------------------------------------------------------------------
module matrix4_determinant_inverse #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ELEM_WIDTH-1:0] elem_value,
    input  logic [3:0]                   elem_index,
    output logic                         strobe,
    output logic signed [ELEM_WIDTH-1:0] inv_value,
    output logic [3:0]                   inv_index,
    output logic signed [ELEM_WIDTH-1:0] det_value,
    output logic                         singular,
    output logic                         run_last
);
    import m4di_pkg::*;

    localparam logic signed [63:0] EMAX = (64'sd1 <<< (ELEM_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] EMIN = -EMAX - 64'sd1;

    // Element and inverse memories
    logic signed [ELEM_WIDTH-1:0] mat_mem [16];
    logic signed [ELEM_WIDTH-1:0] inv_mem [16];
    logic signed [ELEM_WIDTH-1:0] mat_rd_reg, inv_rd_reg;
    logic [3:0] mat_ra, inv_ra, inv_wa;
    logic       inv_we;
    logic signed [ELEM_WIDTH-1:0] inv_wd;

    state_t state_reg, state_next;

    logic [4:0]  term_reg;       // determinant term or cofactor index
    logic [3:0]  sub_reg;        // sub-step within a term
    logic signed [63:0] acc_reg, part_reg;
    logic signed [ELEM_WIDTH-1:0] det_reg;
    logic signed [63:0] recip_reg;
    logic [63:0] div_q_reg, div_r_reg, div_d_reg;
    logic [6:0]  div_cnt_reg;
    logic [4:0]  emit_reg;
    logic        sing_reg;

    // Read data buffer for the current operand set
    logic signed [63:0] opv_reg [9];

    // Multiplier
    logic               mul_start;
    logic signed [63:0] mul_a, mul_b, mul_p;
    logic               mul_done;

    m4di_fmul #(.FRAC_BITS(FRAC_BITS)) u_fmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_p)
    );

    function automatic logic signed [63:0] sat_e(input logic signed [63:0] x);
        if (x > EMAX) return EMAX;
        if (x < EMIN) return EMIN;
        return x;
    endfunction

    // Cofactor operand address: slot s of the 3x3 minor for inverse (r,c)
    function automatic logic [3:0] cof_addr(input logic [3:0] k, input logic [3:0] s);
        logic [1:0] r, c, rr, cc, ri, ci;
        r  = k[3:2];
        c  = k[1:0];
        ci = (s >= 4'd6) ? 2'd2 : ((s >= 4'd3) ? 2'd1 : 2'd0);
        ri = 2'(s - {1'b0, ci, 1'b0} - {2'd0, ci});
        rr = (ri >= c) ? ri + 2'd1 : ri;
        cc = (ci >= r) ? ci + 2'd1 : ci;
        return {rr, cc};
    endfunction

    // Operand address for the read phase
    logic [3:0] rd_slot;
    det_term_t  dt;
    assign dt = det_term(term_reg);

    always_comb
    begin
        mat_ra = 4'd0;
        rd_slot = sub_reg;
        if (state_reg == ST_DET_RD)
        begin
            case (sub_reg[1:0])
                2'd0: mat_ra = dt[16:13];
                2'd1: mat_ra = dt[12:9];
                2'd2: mat_ra = dt[8:5];
                default: mat_ra = dt[4:1];
            endcase
        end
        else
            mat_ra = cof_addr(term_reg[3:0], rd_slot);
    end

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            mat_mem[elem_index] <= elem_value;
        mat_rd_reg <= mat_mem[mat_ra];
        if (inv_we)
            inv_mem[inv_wa] <= inv_wd;
        inv_rd_reg <= inv_mem[inv_ra];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (start && elem_index == 4'd15) state_next = ST_DET_RD;
            ST_DET_RD:   if (sub_reg == 4'd4) state_next = ST_DET_MUL;
            ST_DET_MUL:  if (mul_done && sub_reg == 4'd2) state_next = ST_DET_ACC;
            ST_DET_ACC:  state_next = (term_reg == 5'd23) ? ST_ZERO_CHK : ST_DET_RD;
            ST_ZERO_CHK: state_next = (det_reg == 0) ? ST_EMIT : ST_DIV;
            ST_DIV:      if (div_cnt_reg == 7'd64) state_next = ST_COF_RD;
            ST_COF_RD:   if (sub_reg == 4'd9) state_next = ST_COF_MUL;
            ST_COF_MUL:  if (mul_done && sub_reg == 4'd8) state_next = ST_COF_ACC;
            ST_COF_ACC:  state_next = ST_INV_MUL;
            ST_INV_MUL:  if (mul_done)
                             state_next = (term_reg == 5'd15) ? ST_EMIT : ST_COF_RD;
            ST_EMIT:     if (sing_reg || emit_reg == 5'd16) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Multiplier operands and issue
    logic signed [63:0] recip_f;
    assign recip_f = (term_reg[2] ^ term_reg[0])
                   ? ((recip_reg == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}} : -recip_reg)
                   : recip_reg;

    always_comb
    begin
        mul_start = 1'b0;
        mul_a = '0;
        mul_b = opv_reg[0];
        case (state_reg)
            ST_DET_RD:
            begin
                if (sub_reg == 4'd4)
                begin
                    mul_start = 1'b1;
                    mul_a = opv_reg[0];
                    mul_b = opv_reg[1];
                end
            end
            ST_DET_MUL:
            begin
                mul_start = mul_done && sub_reg != 4'd2;
                mul_a = mul_p;
                mul_b = (sub_reg == 4'd0) ? opv_reg[2] : opv_reg[3];
            end
            ST_COF_RD:
            begin
                // minor order: slot = col*3 + row; x=row0,y=row1,z=row2
                if (sub_reg == 4'd9)
                begin
                    mul_start = 1'b1;
                    mul_a = opv_reg[4];            // y[c1]
                    mul_b = 64'(mat_rd_reg);       // z[c2], landing this cycle
                end
            end
            ST_COF_MUL:
            begin
                mul_start = mul_done && sub_reg != 4'd8;
                case (sub_reg)
                    4'd0: begin mul_a = opv_reg[7]; mul_b = opv_reg[5]; end
                    4'd1: begin mul_a = opv_reg[0]; mul_b = sat_sub64(part_reg, mul_p); end
                    4'd2: begin mul_a = opv_reg[7]; mul_b = opv_reg[2]; end
                    4'd3: begin mul_a = opv_reg[1]; mul_b = opv_reg[8]; end
                    4'd4: begin mul_a = opv_reg[3]; mul_b = sat_sub64(part_reg, mul_p); end
                    4'd5: begin mul_a = opv_reg[1]; mul_b = opv_reg[5]; end
                    4'd6: begin mul_a = opv_reg[4]; mul_b = opv_reg[2]; end
                    default: begin mul_a = opv_reg[6]; mul_b = sat_sub64(part_reg, mul_p); end
                endcase
            end
            ST_COF_ACC:
            begin
                mul_start = 1'b1;
                mul_a = recip_f;
                mul_b = acc_reg;
            end
            default: mul_start = 1'b0;
        endcase
    end

    // Determinant sum and saturated values
    logic signed [63:0] det_sum, det_sat, inv_sat;
    assign det_sum = dt[0] ? sat_sub64(acc_reg, part_reg) : sat_add64(acc_reg, part_reg);
    assign det_sat = sat_e(det_sum);
    assign inv_sat = sat_e(mul_p);

    // Inverse writeback and emit read address
    assign inv_we = (state_reg == ST_INV_MUL) && mul_done;
    assign inv_wa = term_reg[3:0];
    assign inv_wd = inv_sat[ELEM_WIDTH-1:0];
    assign inv_ra = 4'(emit_reg - 5'd1);

    logic [64:0] div_trial;
    assign div_trial = {div_r_reg, div_q_reg[63]} - {1'b0, div_d_reg};

    // Datapath and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            term_reg    <= '0;
            sub_reg     <= '0;
            det_reg     <= '0;
            emit_reg    <= '0;
            sing_reg    <= 1'b0;
            div_cnt_reg <= '0;
            strobe      <= 1'b0;
            run_last    <= 1'b0;
            singular    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            strobe    <= 1'b0;
            run_last  <= 1'b0;
            singular  <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    term_reg <= '0;
                    sub_reg  <= '0;
                    acc_reg  <= '0;
                    emit_reg <= '0;
                    sing_reg <= 1'b0;
                end
                ST_DET_RD:
                begin
                    // read data lands in the cycle after its address
                    if (sub_reg != 4'd0)
                        opv_reg[sub_reg - 4'd1] <= 64'(mat_rd_reg);
                    sub_reg <= (sub_reg == 4'd4) ? 4'd0 : sub_reg + 4'd1;
                end
                ST_DET_MUL:
                begin
                    if (mul_done)
                    begin
                        if (sub_reg == 4'd2)
                            part_reg <= mul_p;
                        sub_reg <= (sub_reg == 4'd2) ? 4'd0 : sub_reg + 4'd1;
                    end
                end
                ST_DET_ACC:
                begin
                    acc_reg  <= det_sum;
                    term_reg <= term_reg + 5'd1;
                    if (term_reg == 5'd23)
                        det_reg <= det_sat[ELEM_WIDTH-1:0];
                end
                ST_ZERO_CHK:
                begin
                    sing_reg    <= (det_reg == 0);
                    div_q_reg   <= 64'd1 << (2 * FRAC_BITS);
                    div_r_reg   <= '0;
                    div_d_reg   <= mag64(64'(det_reg));
                    div_cnt_reg <= '0;
                    term_reg    <= '0;
                    sub_reg     <= '0;
                end
                ST_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    if (div_cnt_reg != 7'd64)
                    begin
                        if (!div_trial[64])
                            div_r_reg <= div_trial[63:0];
                        else
                            div_r_reg <= {div_r_reg[62:0], div_q_reg[63]};
                        div_q_reg   <= {div_q_reg[62:0], ~div_trial[64]};
                        div_cnt_reg <= div_cnt_reg + 7'd1;
                    end
                    else if (div_q_reg[63])
                    begin
                        recip_reg <= det_reg[ELEM_WIDTH-1]
                                   ? -$signed({1'b0, {63{1'b1}}}) : {1'b0, {63{1'b1}}};
                    end
                    else
                    begin
                        recip_reg <= det_reg[ELEM_WIDTH-1]
                                   ? -$signed({1'b0, div_q_reg[62:0]}) : {1'b0, div_q_reg[62:0]};
                    end
                end
                ST_COF_RD:
                begin
                    if (sub_reg != 4'd0)
                        opv_reg[sub_reg - 4'd1] <= 64'(mat_rd_reg);
                    sub_reg <= (sub_reg == 4'd9) ? 4'd0 : sub_reg + 4'd1;
                    acc_reg <= '0;
                end
                ST_COF_MUL:
                begin
                    if (mul_done)
                    begin
                        case (sub_reg)
                            4'd0, 4'd3, 4'd6: part_reg <= mul_p;
                            4'd2, 4'd5, 4'd8: acc_reg <= sat_add64(acc_reg, mul_p);
                            default: part_reg <= part_reg;
                        endcase
                        sub_reg <= (sub_reg == 4'd8) ? 4'd0 : sub_reg + 4'd1;
                    end
                end
                ST_COF_ACC:
                begin
                    sub_reg <= '0;
                end
                ST_INV_MUL:
                begin
                    if (mul_done)
                    begin
                        term_reg <= term_reg + 5'd1;
                        emit_reg <= '0;
                    end
                end
                ST_EMIT:
                begin
                    // inverse read data arrives in the cycle after its address
                    emit_reg <= emit_reg + 5'd1;
                    if (sing_reg)
                    begin
                        strobe   <= 1'b1;
                        singular <= 1'b1;
                        run_last <= 1'b1;
                    end
                    else if (emit_reg != 5'd0)
                    begin
                        strobe   <= 1'b1;
                        run_last <= (emit_reg == 5'd16);
                    end
                end
                default: sub_reg <= '0;
            endcase
        end
    end

    // Result fields
    logic [3:0] out_idx_reg;
    always_ff @(posedge clk)
    begin
        out_idx_reg <= 4'(emit_reg - 5'd1);
    end

    assign busy      = (state_reg != ST_IDLE);
    assign inv_value = singular ? '0 : inv_rd_reg;
    assign inv_index = singular ? 4'd0 : out_idx_reg;
    assign det_value = det_reg;

endmodule
